FILE: rtl/core/sbld_pkg.sv
// Shared types and constants for the single-button LED dimmer core.
// No dependencies; used by sbld_step and single_button_led_dimmer_core.
package sbld_pkg;

  localparam int CntW   = 16;
  localparam int LevelW = 8;
  localparam int KindW  = 2;
  localparam int CfgIdxW = 2;

  localparam logic [CntW-1:0]   CntMax     = 16'hFFFF;
  localparam logic [LevelW-1:0] LevelMax   = 8'd255;
  localparam logic [LevelW-1:0] LevelMin   = 8'd1;
  localparam logic [LevelW-1:0] LevelReset = 8'd127;

  localparam logic [CntW-1:0] DebounceReset  = 16'd20;
  localparam logic [CntW-1:0] LongPressReset = 16'd500;
  localparam logic [CntW-1:0] DimStepReset   = 16'd10;

  // Request kinds carried on in_tuser.
  localparam logic [KindW-1:0] KindTick    = 2'd0;
  localparam logic [KindW-1:0] KindKeyDown = 2'd1;
  localparam logic [KindW-1:0] KindKeyUp   = 2'd2;
  localparam logic [KindW-1:0] KindSetLvl  = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegDebounce  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLongPress = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDimStep   = 2'd2;

  typedef struct packed {
    logic [CntW-1:0] debounce_ms;
    logic [CntW-1:0] long_press_ms;
    logic [CntW-1:0] dim_step_ms;
  } cfg_t;

  typedef struct packed {
    logic              sampled_level;
    logic              down_pending;
    logic              up_pending;
    logic              press_timing;
    logic [CntW-1:0]   press_count;
    logic [CntW-1:0]   sample_count;
    logic [CntW-1:0]   step_count;
    logic              on_flag;
    logic [LevelW-1:0] bright;
    logic              ramp_up;
    logic              ramp_active;
    logic [LevelW-1:0] duty_reg;
  } state_t;

  typedef struct packed {
    logic              report_state;
    logic              dimming;
    logic [LevelW-1:0] level;
    logic              led_on;
    logic [LevelW-1:0] pwm_duty;
  } result_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? CntMax : v + 1'b1;
  endfunction

endpackage

FILE: rtl/core/sbld_step.sv
// Next-state and result logic for one word of the dimmer core.
// Depends on sbld_pkg for the state, configuration and result types.
module sbld_step (
  input  logic [sbld_pkg::KindW-1:0]  kind,
  input  logic                        pin,
  input  logic [sbld_pkg::LevelW-1:0] set_value,
  input  sbld_pkg::cfg_t              cfg,
  input  sbld_pkg::state_t            cur,
  output sbld_pkg::state_t            nxt,
  output sbld_pkg::result_t           res
);

  always_comb begin
    sbld_pkg::state_t s;
    logic report;
    s      = cur;
    report = 1'b0;
    case (kind)
      sbld_pkg::KindTick: begin
        s.sample_count = sbld_pkg::sat_inc(s.sample_count);
        s.press_count  = sbld_pkg::sat_inc(s.press_count);
        s.step_count   = sbld_pkg::sat_inc(s.step_count);
        // Button sampling at the debounce interval.
        if (s.sample_count > cfg.debounce_ms) begin
          s.sample_count = '0;
          if (pin != s.sampled_level) begin
            s.sampled_level = pin;
            if (!pin) begin
              s.down_pending = 1'b1;
            end else begin
              s.up_pending = 1'b1;
            end
          end
        end
        // Long-press detection.
        if (s.down_pending) begin
          if (!s.on_flag) begin
            s.down_pending = 1'b0;
          end else if (!s.press_timing) begin
            s.press_count  = '0;
            s.press_timing = 1'b1;
          end else if (s.press_count > cfg.long_press_ms) begin
            s.ramp_active  = 1'b1;
            s.down_pending = 1'b0;
          end
        end
        // Release: toggle on a short press, reverse the ramp after a long one.
        if (s.up_pending) begin
          s.up_pending   = 1'b0;
          s.down_pending = 1'b0;
          s.press_timing = 1'b0;
          if (!s.on_flag) begin
            s.on_flag  = 1'b1;
            s.duty_reg = s.bright;
            report     = 1'b1;
          end else if (!s.ramp_active) begin
            s.on_flag  = 1'b0;
            s.duty_reg = '0;
            report     = 1'b1;
          end else begin
            s.ramp_up     = ~s.ramp_up;
            s.ramp_active = 1'b0;
          end
        end
        // Dimming ramp, saturating at both ends.
        if (s.ramp_active && (s.step_count > cfg.dim_step_ms)) begin
          s.step_count = '0;
          if (s.ramp_up) begin
            if (s.bright < sbld_pkg::LevelMax) begin
              s.bright   = s.bright + 1'b1;
              s.duty_reg = s.bright;
            end
          end else if (s.bright > sbld_pkg::LevelMin) begin
            s.bright   = s.bright - 1'b1;
            s.duty_reg = s.bright;
          end
        end
      end
      sbld_pkg::KindKeyDown: begin
        s.down_pending = 1'b1;
      end
      sbld_pkg::KindKeyUp: begin
        s.up_pending = 1'b1;
      end
      sbld_pkg::KindSetLvl: begin
        s.duty_reg = set_value;
        s.on_flag  = (set_value != '0);
        report     = 1'b1;
      end
      default: begin
        s = cur;
      end
    endcase
    nxt              = s;
    res.pwm_duty     = s.duty_reg;
    res.led_on       = s.on_flag;
    res.level        = s.bright;
    res.dimming      = s.ramp_active;
    res.report_state = report;
  end

endmodule

FILE: rtl/core/single_button_led_dimmer_core.sv
// Top level of the single-button LED dimmer core: stream ports, state and output buffering.
// Depends on sbld_pkg and sbld_step.

// The core takes one word per clock while in_tready is high and answers every word with
// exactly one result word. An input word is either a one-millisecond tick carrying the
// raw button pin (low means pressed), a remote key down or key up event, or a direct
// set-level request. A tick samples the button every debounce_ms + 1 ms, starts the
// dimming ramp once a press is held longer than long_press_ms while the LED is on, and
// steps the stored level by one every dim_step_ms + 1 ms between 1 and 255. A short
// press toggles the LED; releasing a long press stops the ramp and reverses its
// direction. The state update and result of each word are computed by sbld_step and
// captured in the state registers and in the output buffer at the accepting edge.
// Throughput is one word per cycle while in_tready is high; a two-entry output buffer
// (result register plus skid register) keeps in_tready high while one finished result
// is still waiting, so in_tready falls only when both entries are full.
// Configuration writes are taken at any edge with cfg_we high and should be made while
// the core is idle; indexes beyond the register list are ignored.
module single_button_led_dimmer_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [0] button_level, [8:1] set_value, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] pwm_duty, [8] led_on, [16:9] level,
                                  // [17] dimming, [18] report_state, rest zero
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  sbld_pkg::cfg_t    cfg_r;
  sbld_pkg::state_t  state_r;
  sbld_pkg::state_t  state_nxt;
  sbld_pkg::result_t res_nxt;

  // Output buffer: the result register feeds the port, the skid register catches a
  // word accepted while the result register is stalled.
  sbld_pkg::result_t out_data_r;
  logic              out_valid_r;
  sbld_pkg::result_t skid_data_r;
  logic              skid_valid_r;

  logic in_fire;
  logic out_fire;

  assign in_tready = ~skid_valid_r;
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_valid_r & out_tready;

  sbld_step u_step (
    .kind      (in_tuser),
    .pin       (in_tdata[0]),
    .set_value (in_tdata[8:1]),
    .cfg       (cfg_r),
    .cur       (state_r),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms   <= sbld_pkg::DebounceReset;
      cfg_r.long_press_ms <= sbld_pkg::LongPressReset;
      cfg_r.dim_step_ms   <= sbld_pkg::DimStepReset;
    end else if (cfg_we) begin
      case (cfg_index)
        sbld_pkg::RegDebounce:  cfg_r.debounce_ms   <= cfg_data;
        sbld_pkg::RegLongPress: cfg_r.long_press_ms <= cfg_data;
        sbld_pkg::RegDimStep:   cfg_r.dim_step_ms   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Dimmer state advances on every accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.sampled_level <= 1'b1;
      state_r.down_pending  <= 1'b0;
      state_r.up_pending    <= 1'b0;
      state_r.press_timing  <= 1'b0;
      state_r.press_count   <= '0;
      state_r.sample_count  <= '0;
      state_r.step_count    <= '0;
      state_r.on_flag       <= 1'b0;
      state_r.bright        <= sbld_pkg::LevelReset;
      state_r.ramp_up       <= 1'b0;
      state_r.ramp_active   <= 1'b0;
      state_r.duty_reg      <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Output buffer control. A new word goes to the result register when it is free or
  // being drained this cycle with no skid entry pending; otherwise it lands in skid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_fire) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= in_fire;
        end else begin
          out_valid_r <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
        if (in_fire) begin
          skid_data_r <= res_nxt;
        end
      end else if (in_fire) begin
        out_data_r <= res_nxt;
      end
    end else if (in_fire) begin
      skid_data_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_data_r};

endmodule
